// ===== hdl/elfr_pkg.sv =====
`default_nettype none

package elfr_pkg;

  // Line control characters
  localparam logic [7:0] FlagStart  = 8'h7E;
  localparam logic [7:0] FlagEsc    = 8'h7D;
  localparam logic [7:0] EscOfEsc   = 8'h5D;
  localparam logic [7:0] EscOfStart = 8'h5E;

  // Register file
  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;
  localparam logic RegDestLimit     = 1'b0;
  localparam logic RegLengthOverhead = 1'b1;
  localparam logic [7:0] DestLimitReset      = 8'd127;
  localparam logic [3:0] LengthOverheadReset = 4'd5;

  typedef struct packed {
    logic [7:0] dest_limit;
    logic [3:0] length_overhead;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [8:0] byte_index;
    logic       frame_end;
    logic       frame_accepted;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/elfr_cfg_regs.sv =====
`default_nettype none

module elfr_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [elfr_pkg::AddrWidth-1:0]  paddr,
  input  wire logic [elfr_pkg::DataWidth-1:0]  pwdata,
  output logic      [elfr_pkg::DataWidth-1:0]  prdata,
  output logic                                 pready,
  output elfr_pkg::cfg_t                       cfg_o
);

  elfr_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic           reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_limit      <= elfr_pkg::DestLimitReset;
      cfg_q.length_overhead <= elfr_pkg::LengthOverheadReset;
    end else if (wr_en) begin
      if (reg_sel == elfr_pkg::RegDestLimit) begin
        cfg_q.dest_limit <= pwdata[7:0];
      end else begin
        cfg_q.length_overhead <= pwdata[3:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == elfr_pkg::RegDestLimit) begin
      prdata[7:0] = cfg_q.dest_limit;
    end else begin
      prdata[3:0] = cfg_q.length_overhead;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/elfr_deframe.sv =====
`default_nettype none

module elfr_deframe (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  input  wire elfr_pkg::cfg_t   cfg_i,
  output logic                  res_valid_o,
  output elfr_pkg::result_t     res_o
);

  logic       start_q, start_d;
  logic       esc_q, esc_d;
  logic [8:0] count_q, count_d;
  logic [8:0] size_q, size_d;
  logic [7:0] first_q, first_d;

  logic [7:0] data;
  logic       keep;
  logic [8:0] count_inc;
  logic [8:0] size_eff;

  always_comb begin
    start_d   = start_q;
    esc_d     = esc_q;
    count_d   = count_q;
    size_d    = size_q;
    first_d   = first_q;
    data      = byte_i;
    keep      = 1'b1;
    count_inc = count_q + 9'd1;
    size_eff  = size_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (byte_i == elfr_pkg::FlagStart) begin
      // arm a new frame, abandon any open one
      start_d = 1'b1;
      esc_d   = 1'b0;
      count_d = '0;
    end else if (byte_i == elfr_pkg::FlagEsc) begin
      esc_d = 1'b1;
    end else begin
      if (esc_q) begin
        esc_d = 1'b0;
        if (byte_i == elfr_pkg::EscOfEsc) begin
          data = elfr_pkg::FlagEsc;
        end else if (byte_i == elfr_pkg::EscOfStart) begin
          data = elfr_pkg::FlagStart;
        end else begin
          keep = 1'b0;
        end
      end
      if (keep) begin
        if (start_q) begin
          start_d     = 1'b0;
          first_d     = data;
          count_d     = 9'd1;
          res_valid_o = 1'b1;
        end else if (count_q != '0) begin
          if (count_q == 9'd1) begin
            size_eff = {1'b0, data} + {5'd0, cfg_i.length_overhead};
            size_d   = size_eff;
          end
          res_valid_o      = 1'b1;
          res_o.byte_index = count_q;
          if (count_inc >= size_eff) begin
            res_o.frame_end      = 1'b1;
            res_o.frame_accepted = (first_q < cfg_i.dest_limit);
            count_d              = '0;
          end else begin
            count_d = count_inc;
          end
        end
      end
    end
    res_o.data_byte = data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
      esc_q   <= 1'b0;
      count_q <= '0;
      size_q  <= '0;
      first_q <= '0;
    end else if (step_i) begin
      start_q <= start_d;
      esc_q   <= esc_d;
      count_q <= count_d;
      size_q  <= size_d;
      first_q <= first_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/escaped_length_frame_receiver_unit.sv =====
`default_nettype none

// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+-----------------------------------
// rx        | in        | rx_valid_i / rx_stall_o    | rx_byte_i
// result    | out       | out_valid_o / out_stall_i  | data_byte_o, byte_index_o,
//           |           |                            | frame_end_o, frame_accepted_o
// config    | in        | APB (psel, penable, ...)   | dest_limit, length_overhead
//
// One line byte per cycle is taken while rx_stall_o is low; its result, if any,
// is presented from the result register (input register loads at the transfer
// edge, result register once the deframe step advances on that byte).
// Sustained rate is one byte a cycle while the result is not stalled; the deframe step is combinational.
// Reset clears the frame state and loads the register defaults.
// A stalled result holds the pipeline; rx_stall_o rises only while the input
// register is full and cannot advance.

module escaped_length_frame_receiver_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            rx_valid_i,
  output logic                                 rx_stall_o,
  input  wire logic [7:0]                      rx_byte_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [7:0]                      data_byte_o,
  output logic      [8:0]                      byte_index_o,
  output logic                                 frame_end_o,
  output logic                                 frame_accepted_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [elfr_pkg::AddrWidth-1:0]  paddr,
  input  wire logic [elfr_pkg::DataWidth-1:0]  pwdata,
  output logic      [elfr_pkg::DataWidth-1:0]  prdata,
  output logic                                 pready
);

  elfr_pkg::cfg_t    cfg;
  elfr_pkg::result_t res;
  elfr_pkg::result_t res_q;
  logic              res_valid;
  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q;
  logic              advance;
  logic              load;

  elfr_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance the deframe step whenever the result register is free or draining.
  assign advance    = !out_valid_q || !out_stall_i;
  assign load       = !in_valid_q || advance;
  assign rx_stall_o = !load;

  elfr_deframe u_deframe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_valid_q && advance),
    .byte_i      (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Input register: take a new transfer whenever it is empty or the held byte moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && rx_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Result register: hold while stalled, otherwise refill from the step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign data_byte_o      = res_q.data_byte;
  assign byte_index_o     = res_q.byte_index;
  assign frame_end_o      = res_q.frame_end;
  assign frame_accepted_o = res_q.frame_accepted;

endmodule

`default_nettype wire

// ===== verif/escaped_length_frame_receiver_unit_tb.sv =====
`timescale 1ns / 100ps

module escaped_length_frame_receiver_unit_tb;

  // Generous bound on the whole run, in clock cycles
  localparam int unsigned CycleLimit = 300000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        rx_valid_i = 1'b0;
  logic        rx_stall_o;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  data_byte_o;
  logic [8:0]  byte_index_o;
  logic        frame_end_o;
  logic        frame_accepted_o;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [elfr_pkg::AddrWidth-1:0]  paddr = '0;
  logic [elfr_pkg::DataWidth-1:0]  pwdata = '0;
  logic [elfr_pkg::DataWidth-1:0]  prdata;
  logic                            pready;

  escaped_length_frame_receiver_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_valid_i       (rx_valid_i),
    .rx_stall_o       (rx_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .data_byte_o      (data_byte_o),
    .byte_index_o     (byte_index_o),
    .frame_end_o      (frame_end_o),
    .frame_accepted_o (frame_accepted_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Line bytes waiting to be driven, and unescaped payload bytes still owed
  logic [7:0]        line_bytes[$];
  elfr_pkg::result_t expected_payload[$];
  elfr_pkg::result_t next_payload;
  int unsigned bytes_queued = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;

  // Shadow copy of the deframer state and its registers
  logic       start_armed = 1'b0;
  logic       escape_armed = 1'b0;
  logic [8:0] frame_count = '0;
  logic [8:0] frame_len = '0;
  logic [7:0] frame_head = '0;
  logic [7:0] dest_limit_q = elfr_pkg::DestLimitReset;
  logic [3:0] overhead_q = elfr_pkg::LengthOverheadReset;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Advance the shadow deframer by one accepted line byte; queue the payload
  // byte it yields, if any.
  task automatic deframe_line_byte(input logic [7:0] line_byte);
    elfr_pkg::result_t res;
    logic [7:0]        payload;
    payload = line_byte;
    res = '0;
    if (line_byte == elfr_pkg::FlagStart) begin
      // A start flag always restarts, dropping any open frame and escape
      start_armed = 1'b1;
      escape_armed = 1'b0;
      frame_count = '0;
      return;
    end
    if (line_byte == elfr_pkg::FlagEsc) begin
      escape_armed = 1'b1;
      return;
    end
    if (escape_armed) begin
      escape_armed = 1'b0;
      if (line_byte == elfr_pkg::EscOfEsc) begin
        payload = elfr_pkg::FlagEsc;
      end else if (line_byte == elfr_pkg::EscOfStart) begin
        payload = elfr_pkg::FlagStart;
      end else begin
        // Unknown escape: drop the byte, the index stays put
        return;
      end
    end
    if (start_armed) begin
      start_armed = 1'b0;
      frame_head = payload;
      frame_count = 9'd1;
      res.byte_index = '0;
    end else if (frame_count == '0) begin
      // No frame open: ignore
      return;
    end else begin
      res.byte_index = frame_count;
      if (frame_count == 9'd1) begin
        frame_len = {1'b0, payload} + {5'b0, overhead_q};
      end
      frame_count = frame_count + 9'd1;
      // Short frames end on the length byte itself
      if (frame_count >= frame_len) begin
        res.frame_end = 1'b1;
        res.frame_accepted = (frame_head < dest_limit_q);
        frame_count = '0;
      end
    end
    res.data_byte = payload;
    expected_payload.push_back(res);
  endtask

  // Driver: hold the payload while stalled, advance on each transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_valid_i && !rx_stall_o) begin
        deframe_line_byte(rx_byte_i);
        void'(line_bytes.pop_front());
      end
      if (!rx_valid_i || !rx_stall_o) begin
        if (line_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          rx_valid_i <= 1'b1;
          rx_byte_i <= line_bytes[0];
        end else begin
          rx_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_payload.size() == 0) begin
          report_mismatch($sformatf("unexpected result data %02h index %0d",
                                    data_byte_o, byte_index_o));
        end else begin
          next_payload = expected_payload.pop_front();
          if (data_byte_o !== next_payload.data_byte)
            report_mismatch($sformatf("data_byte %02h, want %02h",
                                      data_byte_o, next_payload.data_byte));
          if (byte_index_o !== next_payload.byte_index)
            report_mismatch($sformatf("byte_index %0d, want %0d",
                                      byte_index_o, next_payload.byte_index));
          if (frame_end_o !== next_payload.frame_end)
            report_mismatch($sformatf("frame_end %b, want %b at index %0d",
                                      frame_end_o, next_payload.frame_end,
                                      next_payload.byte_index));
          if (frame_accepted_o !== next_payload.frame_accepted)
            report_mismatch($sformatf("frame_accepted %b, want %b at index %0d",
                                      frame_accepted_o, next_payload.frame_accepted,
                                      next_payload.byte_index));
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_payload.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // APB write then read back; the shadow register follows the write edge
  task automatic write_register(input logic idx, input logic [7:0] value);
    logic [elfr_pkg::DataWidth-1:0] want;
    want = (idx == elfr_pkg::RegDestLimit) ? {24'b0, value} : {28'b0, value[3:0]};
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= want;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == elfr_pkg::RegDestLimit) dest_limit_q = value;
    else overhead_q = value[3:0];
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want)
      report_mismatch($sformatf("register %0d reads %08h, want %08h", idx, prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    line_bytes.push_back(b);
    bytes_queued++;
  endtask

  // Stuff flag bytes so they travel as payload
  task automatic queue_stuffed(input logic [7:0] b);
    if (b == elfr_pkg::FlagStart) begin
      queue_byte(elfr_pkg::FlagEsc);
      queue_byte(elfr_pkg::EscOfStart);
    end else if (b == elfr_pkg::FlagEsc) begin
      queue_byte(elfr_pkg::FlagEsc);
      queue_byte(elfr_pkg::EscOfEsc);
    end else begin
      queue_byte(b);
    end
  endtask

  // One frame of random content, optionally cut short, with line noise after
  task automatic queue_frame(input logic [7:0] len_field, input bit clip);
    int unsigned total;
    int unsigned stop;
    logic [7:0]  b;
    logic [7:0]  junk;
    // A stray escape just before the flag must be cleared by it
    if ($urandom_range(19) == 0) queue_byte(elfr_pkg::FlagEsc);
    queue_byte(elfr_pkg::FlagStart);
    total = len_field + overhead_q;
    if (total < 2) total = 2;
    stop = clip ? $urandom_range(total - 1) : total;
    for (int unsigned i = 0; i < stop; i++) begin
      if (i == 0) begin
        // Bias the head towards the acceptance threshold
        b = ($urandom_range(3) == 0) ? dest_limit_q - 8'($urandom_range(1))
                                     : 8'($urandom_range(255));
      end else if (i == 1) begin
        b = len_field;
      end else begin
        case ($urandom_range(7))
          0:       b = elfr_pkg::FlagStart;
          1:       b = elfr_pkg::FlagEsc;
          2:       b = elfr_pkg::EscOfEsc;
          3:       b = elfr_pkg::EscOfStart;
          default: b = 8'($urandom_range(255));
        endcase
      end
      if ($urandom_range(24) == 0) begin
        // Escape of an unknown byte: dropped by the receiver
        do junk = 8'($urandom_range(255));
        while (junk == elfr_pkg::FlagStart || junk == elfr_pkg::FlagEsc ||
               junk == elfr_pkg::EscOfEsc || junk == elfr_pkg::EscOfStart);
        queue_byte(elfr_pkg::FlagEsc);
        queue_byte(junk);
      end
      queue_stuffed(b);
    end
    repeat ($urandom_range(2)) queue_byte(8'($urandom_range(255)));
  endtask

  // Let the pipeline run dry so registers can be written safely
  task automatic wait_idle();
    while (line_bytes.size() != 0 || rx_valid_i || expected_payload.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0]  opening [0:24];
    int          dl_set [0:4];
    int          lo_set [0:4];
    int unsigned idle_set [0:4];
    int unsigned stall_set [0:4];
    int unsigned phase_target;
    logic [7:0]  len_field;

    // Noise outside a frame, escaped head, escaped flag, unknown escape,
    // start flag cancelling an escape, escaped last byte, bytes after the end,
    // head of all ones, escaped length byte
    opening = '{8'h00, 8'hFF, elfr_pkg::FlagStart, elfr_pkg::FlagEsc,
                elfr_pkg::EscOfStart, 8'h00, elfr_pkg::FlagEsc, elfr_pkg::EscOfEsc,
                elfr_pkg::FlagEsc, 8'h33, 8'hFF, elfr_pkg::FlagEsc,
                elfr_pkg::FlagStart, 8'h80, 8'h00, 8'h01, 8'h02, elfr_pkg::FlagEsc,
                elfr_pkg::EscOfStart, 8'h55, elfr_pkg::FlagStart, 8'hFF,
                elfr_pkg::FlagEsc, elfr_pkg::FlagEsc, elfr_pkg::EscOfEsc};
    // Per phase: dest_limit, length_overhead (-1 = random), sender idle, stall
    dl_set = '{0, 255, -1, -1, 127};
    lo_set = '{0, 15, -1, -1, 5};
    idle_set = '{0, 63, 0, 8, 0};
    stall_set = '{0, 0, 63, 8, 0};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening at the reset register values
    foreach (opening[i]) queue_byte(opening[i]);
    wait_idle();

    foreach (dl_set[p]) begin
      write_register(elfr_pkg::RegDestLimit,
                     (dl_set[p] < 0) ? 8'($urandom_range(255)) : 8'(dl_set[p]));
      write_register(elfr_pkg::RegLengthOverhead,
                     (lo_set[p] < 0) ? 8'($urandom_range(15)) : 8'(lo_set[p]));
      sender_idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      // Longest frame the index can reach
      if (overhead_q == 4'd15) queue_frame(8'd255, 1'b0);
      phase_target = bytes_queued + 220;
      while (bytes_queued < phase_target) begin
        len_field = ($urandom_range(29) == 0) ? 8'($urandom_range(255))
                                              : 8'($urandom_range(12));
        queue_frame(len_field, $urandom_range(9) == 0);
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/elfr_pkg.sv
hdl/elfr_cfg_regs.sv
hdl/elfr_deframe.sv
hdl/escaped_length_frame_receiver_unit.sv
verif/escaped_length_frame_receiver_unit_tb.sv
